### hdl/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

   localparam int TRUNKS    = 4;
   localparam int CNT_W     = 7;
   localparam int QUEUE_DEP = 2;
   localparam int QPTR_W    = 1;
   localparam int QCNT_W    = 2;

   // frame kinds reported on the result channel
   localparam logic [2:0] FK_NONE    = 3'd0;
   localparam logic [2:0] FK_I       = 3'd1;
   localparam logic [2:0] FK_RR      = 3'd2;
   localparam logic [2:0] FK_UA      = 3'd3;
   localparam logic [2:0] FK_UNKNOWN = 3'd4;

   localparam logic [2:0] TX_LEN_NONE = 3'd0;
   localparam logic [2:0] TX_LEN_U    = 3'd3;
   localparam logic [2:0] TX_LEN_I    = 3'd4;

   // header constants
   localparam logic [7:0] ADDR0_MASK  = 8'hfc;
   localparam logic [7:0] CR_MASK     = 8'h02;
   localparam logic [7:0] EA_BIT      = 8'h01;
   localparam logic [7:0] CTRL_RR     = 8'h01;
   localparam logic [7:0] SABME_MASK  = 8'hef;
   localparam logic [7:0] CTRL_SABME  = 8'h6f;
   localparam logic [7:0] CTRL_UA     = 8'h63;
   localparam logic [7:0] PF_U_MASK   = 8'h10;

   // operations handed from the front to the back
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_SEND_I   = 3'd1;
   localparam logic [2:0] OP_RX_I_ACC = 3'd2;
   localparam logic [2:0] OP_RX_I_REF = 3'd3;
   localparam logic [2:0] OP_RX_RR    = 3'd4;
   localparam logic [2:0] OP_RX_SABME = 3'd5;
   localparam logic [2:0] OP_DROP     = 3'd6;

   typedef struct packed {
      logic       cmd;
      logic [1:0] trunk;
      logic [7:0] rx_octet0;
      logic [7:0] rx_octet1;
      logic [7:0] rx_octet2;
      logic [7:0] rx_octet3;
      logic       upper_accepted;
      logic [5:0] sapi;
      logic       cr_bit;
      logic [6:0] tei;
      logic       pf_bit;
   } req_type;

   typedef struct packed {
      logic       deliver_up;
      logic       send_frame;
      logic [2:0] frame_kind;
      logic [7:0] tx_octet0;
      logic [7:0] tx_octet1;
      logic [7:0] tx_octet2;
      logic [7:0] tx_octet3;
      logic [2:0] tx_length;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] trunk;
      logic [7:0] addr0;
      logic [7:0] addr1;
      logic       poll;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

endpackage

### hdl/lfr_front.sv
`timescale 1ns / 1ps

module lfr_front (
   input  lfr_pkg::req_type      req_word,
   output lfr_pkg::job_type      job
);
   import lfr_pkg::*;

   logic in_range;

   assign in_range = (32'(req_word.trunk) < TRUNKS);

   always_comb begin
      job.trunk = req_word.trunk;
      job.addr0 = req_word.rx_octet0 & (ADDR0_MASK | CR_MASK);
      job.addr1 = req_word.rx_octet1 | EA_BIT;
      job.poll  = req_word.rx_octet3[0];
      if (!in_range) begin
         job.op = OP_NONE;
      end else if (req_word.cmd) begin
         job.op    = OP_SEND_I;
         job.addr0 = {req_word.sapi, req_word.cr_bit, 1'b0};
         job.addr1 = {req_word.tei, 1'b1};
         job.poll  = req_word.pf_bit;
      end else if (!req_word.rx_octet2[0]) begin
         job.op = req_word.upper_accepted ? OP_RX_I_ACC : OP_RX_I_REF;
      end else if (req_word.rx_octet2 == CTRL_RR) begin
         job.op = OP_RX_RR;
      end else if ((req_word.rx_octet2 & SABME_MASK) == CTRL_SABME) begin
         job.op   = OP_RX_SABME;
         // ua final bit mirrors the sabme poll bit
         job.poll = |(req_word.rx_octet2 & PF_U_MASK);
      end else begin
         job.op = OP_DROP;
      end
   end

endmodule

### hdl/lfr_queue.sv
`timescale 1ns / 1ps

module lfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lfr_pkg::job_push_type push,
   output logic                  full,
   output logic                  not_empty,
   output lfr_pkg::job_type      head,
   input  logic                  pop
);
   import lfr_pkg::*;

   job_type             entry_ff [QUEUE_DEP];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEP));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

### hdl/lfr_back.sv
`timescale 1ns / 1ps

module lfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  lfr_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lfr_pkg::rsp_type rsp_payload
);
   import lfr_pkg::*;

   logic [CNT_W-1:0] send_count_ff [TRUNKS];
   logic [CNT_W-1:0] send_count_in [TRUNKS];
   logic [CNT_W-1:0] recv_count_ff [TRUNKS];
   logic [CNT_W-1:0] recv_count_in [TRUNKS];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CNT_W-1:0] sc;
   logic [CNT_W-1:0] rc;
   logic [CNT_W-1:0] rc_inc;

   assign job_pop     = job_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sc     = send_count_ff[job.trunk];
   assign rc     = recv_count_ff[job.trunk];
   assign rc_inc = rc + 1'b1;

   always_comb begin
      send_count_in = send_count_ff;
      recv_count_in = recv_count_ff;
      rsp_in        = '0;
      unique case (job.op)
         OP_SEND_I: begin
            rsp_in.send_frame = 1'b1;
            rsp_in.frame_kind = FK_I;
            rsp_in.tx_octet0  = job.addr0;
            rsp_in.tx_octet1  = job.addr1;
            rsp_in.tx_octet2  = {sc, 1'b0};
            rsp_in.tx_octet3  = {rc, job.poll};
            rsp_in.tx_length  = TX_LEN_I;
            send_count_in[job.trunk] = sc + 1'b1;
         end
         OP_RX_I_ACC: begin
            // acknowledge with the advanced receive count
            rsp_in.deliver_up = 1'b1;
            rsp_in.send_frame = 1'b1;
            rsp_in.frame_kind = FK_RR;
            rsp_in.tx_octet0  = job.addr0;
            rsp_in.tx_octet1  = job.addr1;
            rsp_in.tx_octet2  = CTRL_RR;
            rsp_in.tx_octet3  = {rc_inc, job.poll};
            rsp_in.tx_length  = TX_LEN_I;
            recv_count_in[job.trunk] = rc_inc;
         end
         OP_RX_I_REF: begin
            rsp_in.deliver_up = 1'b1;
         end
         OP_RX_RR: begin
            rsp_in.send_frame = 1'b1;
            rsp_in.frame_kind = FK_RR;
            rsp_in.tx_octet0  = job.addr0;
            rsp_in.tx_octet1  = job.addr1;
            rsp_in.tx_octet2  = CTRL_RR;
            rsp_in.tx_octet3  = {rc, job.poll};
            rsp_in.tx_length  = TX_LEN_I;
         end
         OP_RX_SABME: begin
            rsp_in.send_frame = 1'b1;
            rsp_in.frame_kind = FK_UA;
            rsp_in.tx_octet0  = job.addr0;
            rsp_in.tx_octet1  = job.addr1;
            rsp_in.tx_octet2  = CTRL_UA | (job.poll ? PF_U_MASK : 8'h00);
            rsp_in.tx_length  = TX_LEN_U;
            send_count_in[job.trunk] = '0;
            recv_count_in[job.trunk] = '0;
         end
         OP_DROP: begin
            rsp_in.frame_kind = FK_UNKNOWN;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (job_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TRUNKS; i++) begin
            send_count_ff[i] <= '0;
            recv_count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (job_pop) begin
            send_count_ff <= send_count_in;
            recv_count_ff <= recv_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### hdl/lapd_frame_responder.sv
`timescale 1ns / 1ps
// path: an accepted word is registered in the queue; the back then pops it and registers
// its result in the rsp word, which holds while rsp_ready is low
// throughput: one word per cycle while rsp is taken; the front classifies in the accept
// cycle and the back does the per-trunk count read-modify-write from flip-flop counters
// a two-word queue between front and back keeps req_ready registered, low only when full
// reset: synchronous, clears all send and receive counts, the queue and rsp_valid

module lapd_frame_responder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lfr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lfr_pkg::rsp_type rsp_payload
);
   import lfr_pkg::*;

   job_type      front_job;
   job_push_type push;
   job_type      head;
   logic         q_full;
   logic         q_not_empty;
   logic         q_pop;

   lfr_front u_front (
      .req_word (req_payload),
      .job      (front_job)
   );

   assign push.valid = req_valid && req_ready;
   assign push.job   = front_job;
   assign req_ready  = !q_full;

   lfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head),
      .pop       (q_pop)
   );

   lfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_not_empty),
      .job         (head),
      .job_pop     (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/lfr_checker.sv
`timescale 1ns / 1ps

module lfr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input lfr_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lfr_pkg::rsp_type rsp_payload
);
   import lfr_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.send_frame |->
         rsp_payload.tx_length == TX_LEN_NONE && rsp_payload.tx_octet0 == 8'h00 &&
         rsp_payload.tx_octet3 == 8'h00)
      else $error("header bits present with nothing sent");

   a_sent_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.send_frame |->
         rsp_payload.tx_octet1[0] &&
         (rsp_payload.tx_length == TX_LEN_U || rsp_payload.tx_length == TX_LEN_I))
      else $error("malformed sent header");

   a_deliver_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.deliver_up |->
         rsp_payload.frame_kind == FK_NONE || rsp_payload.frame_kind == FK_RR)
      else $error("delivery with wrong reply kind");

endmodule

bind lapd_frame_responder lfr_checker u_lfr_checker (.*);
